// ===== hw/rtl/rlim_pkg.sv =====
// Shared types and constants of the per-bucket request limiter.
// Used by rlim_ctrl, rlim_dp and the top level; depends on nothing.
package rlim_pkg;

    localparam int BUCKETS    = 256;
    localparam int IDX_W      = $clog2(BUCKETS);
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 32;
    localparam int ACT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int STATUS_W   = 10;
    localparam int CAUSE_W    = 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_W-1:0]    INTERVAL_RESET = CFG_W'(30);
    localparam logic [CFG_W-1:0]    DEFAULT_PURGE  = CFG_W'(30 * 10);
    localparam logic [STATUS_W-1:0] DEFAULT_REJECT = STATUS_W'(503);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACTIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PURGE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT     = 3'd5;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_DONE  = 1'b1;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_RATE   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_CONC   = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_UNCONF = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_PURGE,
        ST_FETCH,
        ST_MUL,
        ST_DEC
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] deadline;
        logic              blocked;
        logic [ACT_W-1:0]  active;
    } entry_t;

    typedef struct packed {
        logic load;
        logic sweep_clr;
        logic sweep_step;
        logic purge_fin;
        logic fetch;
        logic mul;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic quick;
        logic purge_due;
        logic sweep_done;
        logic out_busy;
    } ctl_stat_t;

endpackage

// ===== hw/rtl/rlim_ctrl.sv =====
// Sequencing state machine of the request limiter.
// Depends on rlim_pkg; drives the datapath rlim_dp through command signals.
module rlim_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rlim_pkg::ctl_stat_t stat,
    output rlim_pkg::ctl_cmd_t  cmd
);

    rlim_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rlim_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            rlim_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = rlim_pkg::ST_ISSUE;
                end
            end
            rlim_pkg::ST_ISSUE: begin
                if (stat.quick) begin
                    state_next = rlim_pkg::ST_DEC;
                end else if (stat.purge_due) begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = rlim_pkg::ST_PURGE;
                end else begin
                    state_next = rlim_pkg::ST_FETCH;
                end
            end
            rlim_pkg::ST_PURGE: begin
                if (stat.sweep_done) begin
                    cmd.purge_fin = 1'b1;
                    state_next    = rlim_pkg::ST_ISSUE;
                end else begin
                    cmd.sweep_step = 1'b1;
                end
            end
            rlim_pkg::ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = rlim_pkg::ST_MUL;
            end
            rlim_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = rlim_pkg::ST_DEC;
            end
            rlim_pkg::ST_DEC: begin
                // hold until the output register is free
                if (!stat.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = rlim_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rlim_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rlim_dp.sv =====
// Datapath of the request limiter: config registers, entry memory, valid
// bits, anonymous entry, rate multiplier and output register. Uses rlim_pkg.
module rlim_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rlim_pkg::ctl_cmd_t                 cmd,
    output rlim_pkg::ctl_stat_t                stat,
    input  logic                               cfg_valid,
    input  logic [rlim_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rlim_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_command,
    input  logic                               s_anonymous,
    input  logic [7:0]                         s_bucket,
    input  logic [rlim_pkg::TIME_W-1:0]        s_time_now,
    input  logic                               s_restarted,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_verdict,
    output logic [rlim_pkg::CAUSE_W-1:0]       m_cause,
    output logic [rlim_pkg::STATUS_W-1:0]      m_status_code,
    output logic                               m_slot_taken
);

    localparam int IW = rlim_pkg::IDX_W;
    localparam int TW = rlim_pkg::TIME_W;
    localparam int CW = rlim_pkg::CNT_W;
    localparam int AW = rlim_pkg::ACT_W;
    localparam int FW = rlim_pkg::CFG_W;
    localparam int EW = TW + 1;
    localparam int PW = EW + FW + 1;

    // configuration
    logic [FW-1:0]                  max_rate_reg, max_active_reg, interval_reg, purge_reg;
    logic                           silence_reg;
    logic [rlim_pkg::STATUS_W-1:0]  reject_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rate_reg   <= '0;
            max_active_reg <= '0;
            interval_reg   <= rlim_pkg::INTERVAL_RESET;
            silence_reg    <= 1'b0;
            purge_reg      <= rlim_pkg::DEFAULT_PURGE;
            reject_reg     <= rlim_pkg::DEFAULT_REJECT;
        end else if (cfg_valid) begin
            case (cfg_index)
                rlim_pkg::REG_MAX_RATE:   max_rate_reg   <= cfg_data;
                rlim_pkg::REG_MAX_ACTIVE: max_active_reg <= cfg_data;
                rlim_pkg::REG_INTERVAL:   interval_reg   <= cfg_data;
                rlim_pkg::REG_SILENCE:    silence_reg    <= cfg_data[0];
                rlim_pkg::REG_PURGE:      purge_reg      <= cfg_data;
                rlim_pkg::REG_REJECT:     reject_reg     <= cfg_data[rlim_pkg::STATUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // latched item
    logic          it_cmd_reg, it_anon_reg, it_rst_reg;
    logic [IW-1:0] it_idx_reg;
    logic [TW-1:0] it_now_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            it_cmd_reg  <= s_command;
            it_anon_reg <= s_anonymous;
            it_idx_reg  <= IW'(s_bucket);
            it_now_reg  <= s_time_now;
            it_rst_reg  <= s_restarted;
        end
    end

    // entry memory with registered read
    rlim_pkg::entry_t mem [rlim_pkg::BUCKETS];
    rlim_pkg::entry_t rd_data_reg;
    rlim_pkg::entry_t wr_data;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;

    logic [IW:0]   sw_cnt_reg;
    logic          sw_pend_reg;
    logic [IW-1:0] sw_addr_reg;

    assign rd_addr = cmd.sweep_step ? sw_cnt_reg[IW-1:0] : it_idx_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[it_idx_reg] <= wr_data;
        end
    end

    // anonymous entry, valid bits, purge bookkeeping
    rlim_pkg::entry_t              anon_reg, anon_next;
    logic                          anon_we;
    logic [rlim_pkg::BUCKETS-1:0]  valid_reg;
    logic [TW-1:0]                 next_purge_reg;
    logic                          purged_reg;
    logic                          sw_evict;

    logic unconf;
    assign unconf = (max_rate_reg == '0) && (max_active_reg == '0);

    assign stat.quick = (it_cmd_reg == rlim_pkg::CMD_CHECK) && (it_rst_reg || unconf);
    assign stat.purge_due = (it_cmd_reg == rlim_pkg::CMD_CHECK) && !purged_reg &&
                            (purge_reg != '0) && (it_now_reg > next_purge_reg);
    assign stat.sweep_done = (sw_cnt_reg == (IW+1)'(rlim_pkg::BUCKETS)) && !sw_pend_reg;
    assign stat.out_busy = m_valid && !m_ready;

    // evict the entry read in the previous sweep cycle when idle and slot-free
    assign sw_evict = sw_pend_reg && valid_reg[sw_addr_reg] && (rd_data_reg.active == '0) &&
                      (it_now_reg > rd_data_reg.deadline) &&
                      ((it_now_reg - rd_data_reg.deadline) > TW'(purge_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_cnt_reg  <= '0;
            sw_pend_reg <= 1'b0;
        end else if (cmd.sweep_clr) begin
            sw_cnt_reg  <= '0;
            sw_pend_reg <= 1'b0;
        end else if (cmd.sweep_step) begin
            if (sw_cnt_reg != (IW+1)'(rlim_pkg::BUCKETS)) begin
                sw_cnt_reg  <= sw_cnt_reg + 1'b1;
                sw_pend_reg <= 1'b1;
                sw_addr_reg <= sw_cnt_reg[IW-1:0];
            end else begin
                sw_pend_reg <= 1'b0;
            end
        end
    end

    // working copy of the selected entry
    rlim_pkg::entry_t w_reg;
    logic             w_valid_reg;
    logic [PW-1:0]    prod_reg;
    logic [EW-1:0]    elapsed;

    assign elapsed = EW'(it_now_reg - w_reg.deadline) + EW'(interval_reg);

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            w_reg       <= it_anon_reg ? anon_reg : rd_data_reg;
            w_valid_reg <= it_anon_reg | valid_reg[it_idx_reg];
        end
        if (cmd.mul) begin
            // rate above max_rate exactly when count >= (max_rate+1)*elapsed
            prod_reg <= PW'((FW+1)'(max_rate_reg) + 1'b1) * PW'(elapsed);
        end
    end

    // decision
    logic [CW-1:0]              cnt_inc;
    rlim_pkg::entry_t           upd;
    logic                       reject, slot, blk_new;
    logic [rlim_pkg::CAUSE_W-1:0] cause;
    logic                       new_entry;

    always_comb begin
        cnt_inc   = (w_reg.count == '1) ? w_reg.count : w_reg.count + 1'b1;
        upd       = w_reg;
        reject    = 1'b0;
        slot      = 1'b0;
        cause     = rlim_pkg::CAUSE_NONE;
        blk_new   = w_reg.blocked;
        new_entry = 1'b0;
        wr_en     = 1'b0;
        anon_we   = 1'b0;
        if (it_cmd_reg == rlim_pkg::CMD_DONE) begin
            if (upd.active != '0) begin
                upd.active = upd.active - 1'b1;
            end
            anon_we = it_anon_reg;
            wr_en   = !it_anon_reg && w_valid_reg && (w_reg.active != '0);
        end else if (it_rst_reg) begin
            cause = rlim_pkg::CAUSE_NONE;
        end else if (unconf) begin
            cause = rlim_pkg::CAUSE_UNCONF;
        end else if (!w_valid_reg) begin
            new_entry     = 1'b1;
            upd.count     = CW'(1);
            upd.deadline  = it_now_reg + TW'(interval_reg);
            upd.blocked   = 1'b0;
            upd.active    = '0;
            wr_en         = 1'b1;
        end else begin
            if (max_rate_reg != '0) begin
                upd.count = cnt_inc;
                if (it_now_reg > w_reg.deadline) begin
                    if (PW'(cnt_inc) >= prod_reg) begin
                        blk_new = 1'b1;
                    end else if (!silence_reg || (cnt_inc == CW'(1))) begin
                        blk_new = 1'b0;
                    end
                    upd.count    = '0;
                    upd.deadline = it_now_reg + TW'(interval_reg);
                end
                upd.blocked = blk_new;
                if (blk_new) begin
                    reject = 1'b1;
                    cause  = rlim_pkg::CAUSE_RATE;
                end
            end
            if ((max_active_reg != '0) && !reject) begin
                if (w_reg.active >= max_active_reg) begin
                    reject = 1'b1;
                    cause  = rlim_pkg::CAUSE_CONC;
                end else begin
                    upd.active = w_reg.active + 1'b1;
                    slot       = 1'b1;
                end
            end
            anon_we = it_anon_reg;
            wr_en   = !it_anon_reg;
        end
        if (!cmd.commit) begin
            wr_en   = 1'b0;
            anon_we = 1'b0;
        end
        wr_data   = upd;
        anon_next = upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            anon_reg       <= '0;
            next_purge_reg <= '0;
            purged_reg     <= 1'b0;
        end else begin
            if (sw_evict && cmd.sweep_step) begin
                valid_reg[sw_addr_reg] <= 1'b0;
            end
            if (cmd.commit && new_entry && !it_anon_reg) begin
                valid_reg[it_idx_reg] <= 1'b1;
            end
            if (anon_we) begin
                anon_reg <= anon_next;
            end
            if (cmd.load) begin
                purged_reg <= 1'b0;
            end else if (cmd.purge_fin) begin
                purged_reg     <= 1'b1;
                next_purge_reg <= it_now_reg + TW'(purge_reg);
            end
        end
    end

    // output register
    logic                          m_valid_reg, m_verdict_reg, m_slot_reg;
    logic [rlim_pkg::CAUSE_W-1:0]  m_cause_reg;
    logic [rlim_pkg::STATUS_W-1:0] m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.commit) begin
            m_verdict_reg <= reject;
            m_cause_reg   <= cause;
            m_status_reg  <= reject ? reject_reg : '0;
            m_slot_reg    <= slot;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_verdict     = m_verdict_reg;
    assign m_cause       = m_cause_reg;
    assign m_status_code = m_status_reg;
    assign m_slot_taken  = m_slot_reg;

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_valid_reg && !m_ready))
        else $error("result overwrote a word still waiting");
    a_slot_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_slot_reg && m_verdict_reg))
        else $error("slot taken on a rejected request");
    a_pass_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_verdict_reg) |-> (m_status_reg == '0))
        else $error("status code on a passed request");
    a_purge_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.purge_fin |=> (purged_reg && !stat.purge_due))
        else $error("purge sweep would repeat for one item");

endmodule

// ===== hw/rtl/per_bucket_request_rate_limiter_top.sv =====
// Top level of the per-bucket request limiter.
// Depends on rlim_pkg, rlim_ctrl and rlim_dp.
//
// Input channel (s_*): one word per request check (command 0) or request
// done (command 1), selecting the anonymous entry or a table bucket.
// Result channel (m_*): exactly one word per input word, in order.
// Config channel (cfg_*): always ready; write only while the block is idle.
//
// Steps: a plain word passes issue, fetch, multiply and decide from
// acceptance to result; restarted or unconfigured checks go from issue
// straight to decide. Any other check that finds the purge period expired
// first sweeps all 256 table entries, one memory read a cycle.
// The block takes one word at a time and accepts the next word only after
// the last one has been decided.
//
// Reset clears the configuration to defaults, all table valid bits, the
// anonymous entry and the purge timer at once; no clearing pass is needed.
// When the receiver stalls, the finished word holds in the output
// register while the next word is accepted and worked up to its decision.
module per_bucket_request_rate_limiter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic                               s_anonymous,
    input  logic [7:0]                         s_bucket,
    input  logic [rlim_pkg::TIME_W-1:0]        s_time_now,
    input  logic                               s_restarted,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_verdict,
    output logic [rlim_pkg::CAUSE_W-1:0]       m_cause,
    output logic [rlim_pkg::STATUS_W-1:0]      m_status_code,
    output logic                               m_slot_taken,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rlim_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rlim_pkg::CFG_W-1:0]         cfg_data
);

    rlim_pkg::ctl_cmd_t  cmd;
    rlim_pkg::ctl_stat_t stat;

    // configuration writes go straight into the registers
    assign cfg_ready = 1'b1;

    rlim_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rlim_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_command     (s_command),
        .s_anonymous   (s_anonymous),
        .s_bucket      (s_bucket),
        .s_time_now    (s_time_now),
        .s_restarted   (s_restarted),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_cause       (m_cause),
        .m_status_code (m_status_code),
        .m_slot_taken  (m_slot_taken)
    );

endmodule
